// ===== hdl/grid_axis_wall_cast_core_macros.svh =====
// Assertion macros for the grid_axis_wall_cast_core RTL.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef GRID_AXIS_WALL_CAST_CORE_MACROS_SVH
`define GRID_AXIS_WALL_CAST_CORE_MACROS_SVH

`ifndef SYNTH
// Plain invariant, checked every cycle out of reset.
`define GAWC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Condition in one cycle implies consequence in the next.
`define GAWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GAWC_ASSERT(lbl, cond, msg)
`define GAWC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/gawc_pkg.sv =====
// Shared types, widths and codes for the grid wall cast core.
// No dependencies; imported by every module of the block.
package gawc_pkg;

  localparam int CELL_PIXELS_DEF = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_ROWS_DEF    = 64;

  localparam int POS_W  = 12;
  localparam int CELL_W = 6;
  localparam int LIM_W  = 7;
  localparam int BND_W  = 13;
  localparam int DIR_W  = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd1;

  localparam logic [LIM_W-1:0] GRID_RESET = 7'd64;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [DIR_W-1:0]  direction;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
    logic              cell_is_wall;
  } in_item_t;

  typedef struct packed {
    logic [LIM_W-1:0] cols;
    logic [LIM_W-1:0] rows;
  } grid_lim_t;

  typedef struct packed {
    logic             hit;
    logic [BND_W-1:0] boundary;
  } cast_res_t;

endpackage

// ===== hdl/gawc_div.sv =====
// Divide-by-constant for the cast origin, two lanes, by reciprocal multiplication.
// Turns pixel coordinates into cell indices, registered in the cycle after start; uses gawc_pkg.
module gawc_div #(
  parameter int DIVISOR = gawc_pkg::CELL_PIXELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gawc_pkg::POS_W-1:0] a_in,
  input  logic [gawc_pkg::POS_W-1:0] b_in,
  output logic                       done,
  output logic [gawc_pkg::POS_W-1:0] qa,
  output logic [gawc_pkg::POS_W-1:0] qb
);
  import gawc_pkg::*;

  // floor(a / D) == (a * M) >> SH for every POS_W-bit a, with M = ceil(2^SH / D)
  localparam int SH    = POS_W + $clog2(DIVISOR);
  localparam int MUL_W = SH + POS_W;
  localparam int RECIP = ((1 << SH) + DIVISOR - 1) / DIVISOR;

  logic             done_r;
  logic [POS_W-1:0] qa_r;
  logic [POS_W-1:0] qb_r;
  logic [MUL_W-1:0] prod_a;
  logic [MUL_W-1:0] prod_b;

  assign prod_a = MUL_W'(a_in) * MUL_W'(RECIP);
  assign prod_b = MUL_W'(b_in) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa_r <= prod_a[SH +: POS_W];
      qb_r <= prod_b[SH +: POS_W];
    end
  end

  assign done = done_r;
  assign qa   = qa_r;
  assign qb   = qb_r;

endmodule

// ===== hdl/gawc_walk.sv =====
// Wall bit map memory and the cast sequencer that walks it one cell per cycle.
// Uses gawc_pkg, gawc_div and the assertion macros header.
`include "grid_axis_wall_cast_core_macros.svh"

module gawc_walk #(
  parameter int CELL_PIXELS = gawc_pkg::CELL_PIXELS_DEF,
  parameter int MAX_COLS    = gawc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = gawc_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gawc_pkg::in_item_t  in_item,
  input  gawc_pkg::grid_lim_t lim,
  output logic                res_valid,
  input  logic                res_ready,
  output gawc_pkg::cast_res_t res
);
  import gawc_pkg::*;

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [DIR_W-1:0] dir_r, dir_nxt;
  logic [LIM_W-1:0] perp_r, perp_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [LIM_W-1:0] k_r, k_nxt;
  logic [LIM_W-1:0] kp_r, kp_nxt;
  logic             pend_r, pend_nxt;
  cast_res_t        res_r, res_nxt;

  logic             mem [DEPTH];
  logic             rd_bit_r;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             wr_en;

  logic             in_acc;
  logic             cast_acc;
  logic             div_start;
  logic             div_done;
  logic [POS_W-1:0] div_qa;
  logic [POS_W-1:0] div_qb;

  logic             hor;
  logic             pos;
  logic [POS_W-1:0] along;
  logic [POS_W-1:0] perp_q;
  logic [POS_W:0]   along_p1;
  logic [LIM_W-1:0] lim_along;
  logic [LIM_W-1:0] lim_perp;
  logic             perp_ok;
  logic             walk_ok;
  logic             issue;
  logic [LIM_W-1:0] cell_idx;
  logic [LIM_W-1:0] row_idx;
  logic [LIM_W-1:0] col_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cast_acc  = in_acc && (in_item.req_type == REQ_CAST);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  gawc_div #(
    .DIVISOR (CELL_PIXELS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a_in  (in_item.pos_x),
    .b_in  (in_item.pos_y),
    .done  (div_done),
    .qa    (div_qa),
    .qb    (div_qb)
  );

  assign hor = (dir_r == DIR_RIGHT) || (dir_r == DIR_LEFT);
  assign pos = (dir_r == DIR_RIGHT) || (dir_r == DIR_DOWN);

  assign along     = hor ? div_qa : div_qb;
  assign perp_q    = hor ? div_qb : div_qa;
  assign along_p1  = (POS_W + 1)'(along) + 1'b1;
  assign lim_along = hor ? lim.cols : lim.rows;
  assign lim_perp  = hor ? lim.rows : lim.cols;
  assign perp_ok   = (perp_q < POS_W'(lim_perp));
  // Negative walks start at the origin cell index and check the cell below it.
  assign walk_ok   = pos ? (along_p1 < (POS_W + 1)'(lim_along))
                         : ((along <= POS_W'(lim_along)) && (along != '0));

  assign issue    = pos ? (k_r < lim_r) : (k_r != '0);
  assign cell_idx = pos ? k_r : (k_r - 1'b1);
  assign row_idx  = hor ? perp_r : cell_idx;
  assign col_idx  = hor ? cell_idx : perp_r;
  assign raddr    = {RW'(row_idx), CW'(col_idx)};

  assign waddr = {RW'(in_item.cell_row), CW'(in_item.cell_col)};
  assign wr_en = in_acc && (in_item.req_type == REQ_WRITE)
              && (int'(in_item.cell_col) < MAX_COLS)
              && (int'(in_item.cell_row) < MAX_ROWS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= in_item.cell_is_wall;
    end
    rd_bit_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    perp_nxt  = perp_r;
    lim_nxt   = lim_r;
    k_nxt     = k_r;
    kp_nxt    = kp_r;
    pend_nxt  = pend_r;
    res_nxt   = res_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cast_acc) begin
          dir_nxt   = in_item.direction;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        perp_nxt = LIM_W'(perp_q);
        lim_nxt  = lim_along;
        k_nxt    = pos ? LIM_W'(along_p1) : LIM_W'(along);
        pend_nxt = 1'b0;
        if (perp_ok && walk_ok) begin
          state_nxt = S_WALK;
        end else begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        // Read for cell k issues while the previous cell's bit is tested.
        if (pend_r && rd_bit_r) begin
          res_nxt.hit      = 1'b1;
          res_nxt.boundary = BND_W'(kp_r * CELL_PIXELS);
          pend_nxt         = 1'b0;
          state_nxt        = S_DONE;
        end else if (issue) begin
          pend_nxt = 1'b1;
          kp_nxt   = k_r;
          k_nxt    = pos ? (k_r + 1'b1) : (k_r - 1'b1);
        end else begin
          pend_nxt  = 1'b0;
          res_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r  <= dir_nxt;
    perp_r <= perp_nxt;
    lim_r  <= lim_nxt;
    k_r    <= k_nxt;
    kp_r   <= kp_nxt;
    res_r  <= res_nxt;
  end

  `GAWC_ASSERT(a_pend_walk, !pend_r || state_r == S_WALK, "read pending outside walk")
  `GAWC_ASSERT(a_div_sync, !div_done || state_r == S_DIV, "divider finished while not waited on")
  `GAWC_ASSERT(a_k_range, state_r != S_WALK || k_r <= lim_r, "walk index beyond map limit")
  `GAWC_ASSERT_NEXT(a_cast_div, cast_acc, state_r == S_DIV, "cast did not start the divider")

endmodule

// ===== hdl/grid_axis_wall_cast_core.sv =====
// Top level of the grid wall cast core: stream ports, config registers, result register.
// Uses gawc_pkg and gawc_walk.
//
//  port group | dir | contents
//  in_*       | in  | write-cell or cast transaction, kind in in_tuser
//  out_*      | out | one result per cast: hit flag and boundary pixel
//  cfg_*      | in  | grid_cols (index 0), grid_rows (index 1)
//
// A cell write is stored as it is taken. After a cast is taken, the origin is split
// into cell indices (reciprocal multiply), a setup state loads the walk, the walk
// reads one map cell per cycle, and the result is handed off; only then is the next
// transaction taken. A cast that misses at setup goes from setup to the hand-off.
// Reset is synchronous; the map itself is not cleared. A new transaction is
// taken while a result still waits in the output register; the hand-off stalls
// while that register is full and out_tready is low.
module grid_axis_wall_cast_core #(
  parameter int CELL_PIXELS = gawc_pkg::CELL_PIXELS_DEF,
  parameter int MAX_COLS    = gawc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = gawc_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // direction[1:0], pos_x[13:2], pos_y[25:14], cell_col[31:26],
  // cell_row[37:32], cell_is_wall[38], zero pad [39]
  input  logic [gawc_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], boundary[13:1], zero pad [15:14]
  output logic [gawc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [gawc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gawc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gawc_pkg::*;

  logic [LIM_W-1:0] grid_cols_r;
  logic [LIM_W-1:0] grid_rows_r;
  grid_lim_t        lim;
  in_item_t         item;
  logic             res_valid;
  logic             res_ready;
  cast_res_t        res;
  logic             out_tvalid_r;
  cast_res_t        out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_RESET;
      grid_rows_r <= GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_COLS: grid_cols_r <= cfg_data;
        CFG_GRID_ROWS: grid_rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limits saturate at the store size.
  assign lim.cols = (int'(grid_cols_r) > MAX_COLS) ? LIM_W'(MAX_COLS) : grid_cols_r;
  assign lim.rows = (int'(grid_rows_r) > MAX_ROWS) ? LIM_W'(MAX_ROWS) : grid_rows_r;

  assign item.req_type     = in_tuser;
  assign item.direction    = in_tdata[1:0];
  assign item.pos_x        = in_tdata[13:2];
  assign item.pos_y        = in_tdata[25:14];
  assign item.cell_col     = in_tdata[31:26];
  assign item.cell_row     = in_tdata[37:32];
  assign item.cell_is_wall = in_tdata[38];

  gawc_walk #(
    .CELL_PIXELS (CELL_PIXELS),
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .lim       (lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_res_r.boundary, out_res_r.hit};

endmodule

// ===== tb/sv/grid_axis_wall_cast_core_tb.sv =====
// Self-checking testbench for grid_axis_wall_cast_core: loads the wall map, then runs
// directed and random cast/write traffic under several grid settings with random stalls.
// Depends on gawc_pkg and the grid_axis_wall_cast_core RTL.
module grid_axis_wall_cast_core_tb;
  import gawc_pkg::*;

  localparam int CELL_PX     = CELL_PIXELS_DEF;
  localparam int COLS_MAX    = MAX_COLS_DEF;
  localparam int ROWS_MAX    = MAX_ROWS_DEF;
  localparam int SETTLE_CYC  = 100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 90;
  // rows 0..BAND-1 and columns 0..BAND-1 are loaded in full
  localparam int BAND        = 8;
  localparam int ITEM_W      = $bits(in_item_t);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_axis_wall_cast_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // model state
  bit               wall_map [ROWS_MAX][COLS_MAX];
  logic [LIM_W-1:0] cols_cfg = GRID_RESET;
  logic [LIM_W-1:0] rows_cfg = GRID_RESET;

  in_item_t  pending_items [$];
  cast_res_t expected_casts [$];
  in_item_t  in_cur;

  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  bit no_idle  = 1'b0;
  int in_wait  = 0;
  int out_wait = 0;
  int cycle_count = 0;
  int err_count   = 0;
  int casts_done  = 0;
  int hits_done   = 0;
  int writes_done = 0;
  int grids_done  = 0;

  function automatic cast_res_t cast_expect(in_item_t it);
    cast_res_t r;
    int cols, rows, along, perp, lim_along, lim_perp, k;
    bit horiz, positive, w;
    r = '0;
    cols = (cols_cfg > COLS_MAX) ? COLS_MAX : int'(cols_cfg);
    rows = (rows_cfg > ROWS_MAX) ? ROWS_MAX : int'(rows_cfg);
    horiz = (it.direction == DIR_RIGHT) || (it.direction == DIR_LEFT);
    positive = (it.direction == DIR_RIGHT) || (it.direction == DIR_DOWN);
    along = int'(horiz ? it.pos_x : it.pos_y) / CELL_PX;
    perp  = int'(horiz ? it.pos_y : it.pos_x) / CELL_PX;
    lim_along = horiz ? cols : rows;
    lim_perp  = horiz ? rows : cols;
    if (perp < lim_perp) begin
      if (positive) begin
        for (k = along + 1; k < lim_along; k++) begin
          w = horiz ? wall_map[perp][k] : wall_map[k][perp];
          if (w) begin
            r.hit = 1'b1;
            r.boundary = BND_W'(k * CELL_PX);
            break;
          end
        end
      end else if (along <= lim_along) begin
        // walking toward 0: the wall cell is k-1, its high edge is k
        for (k = along; k > 0; k--) begin
          w = horiz ? wall_map[perp][k-1] : wall_map[k-1][perp];
          if (w) begin
            r.hit = 1'b1;
            r.boundary = BND_W'(k * CELL_PX);
            break;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_cast(logic [DIR_W-1:0] dir, int x, int y);
    in_item_t it;
    it = in_item_t'(ITEM_W'({$urandom, $urandom}));
    it.req_type  = REQ_CAST;
    it.direction = dir;
    it.pos_x     = POS_W'(x);
    it.pos_y     = POS_W'(y);
    return it;
  endfunction

  function automatic in_item_t make_write(int col, int row, bit wall);
    in_item_t it;
    it = in_item_t'(ITEM_W'({$urandom, $urandom}));
    it.req_type     = REQ_WRITE;
    it.cell_col     = CELL_W'(col);
    it.cell_row     = CELL_W'(row);
    it.cell_is_wall = wall;
    return it;
  endfunction

  function automatic int gap_draw();
    return no_idle ? 0 : int'($urandom_range(0, 11));
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_wait > 0) begin
        in_tvalid <= 1'b0;
        in_wait = in_wait - 1;
      end else if (pending_items.size() > 0) begin
        in_cur = pending_items.pop_front();
        in_tdata <= {1'b0, in_cur.cell_is_wall, in_cur.cell_row, in_cur.cell_col,
                     in_cur.pos_y, in_cur.pos_x, in_cur.direction};
        in_tuser <= in_cur.req_type;
        in_tvalid <= 1'b1;
        in_wait = gap_draw();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result-side ready with random back-pressure
  always @(negedge clk) begin
    if (out_fire) out_wait = gap_draw();
    if (out_wait > 0) begin
      out_tready <= 1'b0;
      out_wait = out_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: prediction on input transactions, check on result transactions
  always @(posedge clk) begin
    cast_res_t want, got;
    cycle_count = cycle_count + 1;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      if (in_cur.req_type == REQ_CAST) begin
        expected_casts.push_back(cast_expect(in_cur));
      end else begin
        wall_map[in_cur.cell_row][in_cur.cell_col] = in_cur.cell_is_wall;
        writes_done++;
      end
    end
    if (out_fire) begin
      got.hit      = out_tdata[0];
      got.boundary = out_tdata[BND_W:1];
      if (expected_casts.size() == 0) begin
        $error("unexpected result transaction: hit %0d boundary %0d", got.hit, got.boundary);
        err_count++;
      end else begin
        want = expected_casts.pop_front();
        casts_done++;
        if (got.hit) hits_done++;
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          err_count++;
        end
        if (got.boundary !== want.boundary) begin
          $error("boundary: expected %0d, got %0d", want.boundary, got.boundary);
          err_count++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_casts.size());
      $display("grid_axis_wall_cast_core_tb: FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_casts.size() > 0)
      @(posedge clk);
    // a cell write leaves no result behind, give it time to retire
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_grid(int cols, int rows);
    drain();
    grids_done++;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_COLS;
    cfg_data  <= LIM_W'(cols);
    cols_cfg  = LIM_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= LIM_W'(rows);
    rows_cfg  = LIM_W'(rows);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int cols, int rows, int n);
    int i, ce, re, band_x, band_y, x, y;
    logic [DIR_W-1:0] dir;
    set_grid(cols, rows);
    no_idle = ($urandom_range(0, 3) == 0);
    ce = (cols > COLS_MAX) ? COLS_MAX : cols;
    re = (rows > ROWS_MAX) ? ROWS_MAX : rows;
    band_x = ((ce < BAND) ? ce : BAND) * CELL_PX;
    band_y = ((re < BAND) ? re : BAND) * CELL_PX;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        pending_items.push_back(make_write($urandom_range(0, COLS_MAX - 1),
                                           $urandom_range(0, ROWS_MAX - 1),
                                           $urandom_range(0, 5) == 0));
      end else begin
        dir = DIR_W'($urandom_range(0, 3));
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        // across the axis: inside the loaded band or off the map; along it: mostly on the map
        if (dir == DIR_RIGHT || dir == DIR_LEFT) begin
          if (band_y > 0 && (re * CELL_PX > 4095 || $urandom_range(0, 9) < 8))
            y = $urandom_range(0, band_y - 1);
          else
            y = $urandom_range(re * CELL_PX, 4095);
          if (ce > 0 && $urandom_range(0, 9) < 8)
            x = $urandom_range(0, ce * CELL_PX - 1);
        end else begin
          if (band_x > 0 && (ce * CELL_PX > 4095 || $urandom_range(0, 9) < 8))
            x = $urandom_range(0, band_x - 1);
          else
            x = $urandom_range(ce * CELL_PX, 4095);
          if (re > 0 && $urandom_range(0, 9) < 8)
            y = $urandom_range(0, re * CELL_PX - 1);
        end
        pending_items.push_back(make_cast(dir, x, y));
      end
    end
  endtask

  initial begin
    int r, c, d, p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // load the first rows and columns in full; casts only walk those lines
    set_grid(64, 64);
    for (r = 0; r < ROWS_MAX; r++)
      for (c = 0; c < COLS_MAX; c++)
        if (r < BAND || c < BAND)
          pending_items.push_back(make_write(c, r, $urandom_range(0, 7) == 0));

    // corners and middle, every direction
    for (d = 0; d < 4; d++) begin
      if (d == int'(DIR_RIGHT) || d == int'(DIR_LEFT)) begin
        pending_items.push_back(make_cast(DIR_W'(d), 0, 0));
        pending_items.push_back(make_cast(DIR_W'(d), 4095, 448));
        pending_items.push_back(make_cast(DIR_W'(d), 2047, 200));
      end else begin
        pending_items.push_back(make_cast(DIR_W'(d), 0, 0));
        pending_items.push_back(make_cast(DIR_W'(d), 448, 4095));
        pending_items.push_back(make_cast(DIR_W'(d), 200, 2112));
      end
    end
    pending_items.push_back(make_write(63, 0, 1'b1));
    pending_items.push_back(make_cast(DIR_RIGHT, 0, 10));

    // small grid: origin off-map across the axis, beyond the far edge, from cell 0
    set_grid(5, 3);
    pending_items.push_back(make_cast(DIR_RIGHT, 10, 192));
    pending_items.push_back(make_cast(DIR_LEFT, 6 * 64, 100));
    pending_items.push_back(make_cast(DIR_LEFT, 5 * 64 + 10, 100));
    pending_items.push_back(make_cast(DIR_UP, 100, 10));
    pending_items.push_back(make_cast(DIR_DOWN, 320, 10));

    // empty map, then saturating registers
    set_grid(0, 0);
    pending_items.push_back(make_cast(DIR_RIGHT, 0, 0));
    pending_items.push_back(make_cast(DIR_UP, 4095, 4095));
    set_grid(127, 127);
    pending_items.push_back(make_cast(DIR_DOWN, 300, 0));
    pending_items.push_back(make_cast(DIR_LEFT, 4095, 300));

    random_phase(64, 64, PHASE_ITEMS);
    random_phase(1, 1, PHASE_ITEMS);
    random_phase(127, 100, PHASE_ITEMS);
    random_phase(0, 40, PHASE_ITEMS);
    random_phase(64, 1, PHASE_ITEMS);
    random_phase(1, 64, PHASE_ITEMS);
    for (p = 0; p < 3; p++)
      random_phase($urandom_range(1, 64), $urandom_range(1, 64), PHASE_ITEMS);
    drain();
    no_idle = 1'b0;

    $display("covered %0d cell writes and %0d casts (%0d hits) over %0d grid settings",
             writes_done, casts_done, hits_done, grids_done);
    $display("%0d mismatches in %0d cycles", err_count, cycle_count);
    if (err_count == 0)
      $display("grid_axis_wall_cast_core_tb: PASS");
    else
      $display("grid_axis_wall_cast_core_tb: FAIL");
    $finish;
  end

endmodule
